// File: design/vfd_pkg.sv
package vfd_pkg;

  localparam int CELL_LIMIT     = 12;
  localparam int MAX_DIGITS_DEF = 12;

  localparam logic [3:0] DIGIT_COUNT_RST = 4'd12;

  localparam logic [7:0] CMD_RAM_WRITE = 8'h10;
  localparam logic [7:0] CMD_DUTY      = 8'h50;
  localparam logic [7:0] CMD_DIGITS    = 8'h60;
  localparam logic [7:0] CMD_LIGHTS    = 8'h70;
  localparam logic [7:0] LIGHTS_NORMAL = 8'h00;
  localparam logic [7:0] SPACE_CODE    = 8'd48;
  localparam logic [7:0] BAD_CODE      = 8'd79;
  localparam logic [7:0] LEVEL_MAX     = 8'd15;
  localparam logic [3:0] DUTY_INIT     = 4'd8;

  localparam logic [2:0] KIND_SET_CHAR   = 3'd0;
  localparam logic [2:0] KIND_BRIGHTNESS = 3'd1;
  localparam logic [2:0] KIND_CLEAR      = 3'd2;
  localparam logic [2:0] KIND_WRITE      = 3'd3;
  localparam logic [2:0] KIND_INIT       = 3'd4;

  // microprogram addresses
  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_SETCHAR,
    STEP_BRIGHT,
    STEP_CLEAR,
    STEP_INIT0,
    STEP_INIT1,
    STEP_INIT2,
    STEP_WRCMD,
    STEP_WRCELL
  } step_t;

  typedef enum logic [2:0] {
    SRC_DUTY_LVL,
    SRC_DUTY_INIT,
    SRC_DIGITS,
    SRC_LIGHTS,
    SRC_RAM_WRITE,
    SRC_CELL
  } src_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SETCHAR,
    ACT_CLEAR,
    ACT_LOAD_CNT,
    ACT_DEC_CNT
  } act_t;

  typedef enum logic {
    BR_JUMP,
    BR_COND
  } br_t;

  typedef enum logic {
    COND_NZERO,
    COND_CNT1
  } cond_t;

  typedef struct packed {
    logic  emit;
    src_t  src;
    logic  fend_fix;
    act_t  act;
    br_t   br;
    cond_t csel;
    step_t nxt;
  } ctrl_word_t;

  typedef struct packed {
    logic       load;
    logic       go;
    logic       last;
    logic       fend;
    ctrl_word_t word;
  } seq_ctrl_t;

  typedef struct packed {
    logic n_zero;
    logic cnt_one;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] rom_code(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'd64 && c <= 8'd95) begin
      r = c - 8'd48;
    end else if (c >= 8'd32 && c <= 8'd63) begin
      r = c + 8'd16;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = c - 8'd80;
    end else begin
      r = BAD_CODE;
    end
    return r;
  endfunction

endpackage

// File: design/vfd_if.sv
interface vfd_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [4:0] position;
  logic [7:0]        character;
  logic [7:0]        level;

  modport source (output valid, output kind, output position, output character,
                  output level, input ready);
  modport sink (input valid, input kind, input position, input character,
                input level, output ready);
endinterface

interface vfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       frame_end;
  logic       last;

  modport source (output valid, output bus_byte, output frame_end, output last,
                  input ready);
  modport sink (input valid, input bus_byte, input frame_end, input last,
                output ready);
endinterface

// File: design/vfd_seq.sv
module vfd_seq (
  input  logic              clk,
  input  logic              rst_n,
  vfd_in_if.sink            in_ch,
  input  vfd_pkg::dp_stat_t stat,
  output vfd_pkg::seq_ctrl_t ctrl
);

  vfd_pkg::step_t      upc_r;
  vfd_pkg::step_t      upc_nxt;
  vfd_pkg::ctrl_word_t word;
  logic                cond_hit;
  logic                done;

  function automatic vfd_pkg::ctrl_word_t microcode(input vfd_pkg::step_t s);
    vfd_pkg::ctrl_word_t w;
    w = '{emit: 1'b0, src: vfd_pkg::SRC_RAM_WRITE, fend_fix: 1'b0,
          act: vfd_pkg::ACT_NONE, br: vfd_pkg::BR_JUMP,
          csel: vfd_pkg::COND_NZERO, nxt: vfd_pkg::STEP_IDLE};
    unique case (s)
      vfd_pkg::STEP_IDLE: begin
      end
      vfd_pkg::STEP_SETCHAR: begin
        w.act = vfd_pkg::ACT_SETCHAR;
      end
      vfd_pkg::STEP_BRIGHT: begin
        w.emit     = 1'b1;
        w.src      = vfd_pkg::SRC_DUTY_LVL;
        w.fend_fix = 1'b1;
      end
      vfd_pkg::STEP_CLEAR: begin
        w.act = vfd_pkg::ACT_CLEAR;
      end
      vfd_pkg::STEP_INIT0: begin
        w.emit     = 1'b1;
        w.src      = vfd_pkg::SRC_DIGITS;
        w.fend_fix = 1'b1;
        w.nxt      = vfd_pkg::STEP_INIT1;
      end
      vfd_pkg::STEP_INIT1: begin
        w.emit     = 1'b1;
        w.src      = vfd_pkg::SRC_DUTY_INIT;
        w.fend_fix = 1'b1;
        w.nxt      = vfd_pkg::STEP_INIT2;
      end
      vfd_pkg::STEP_INIT2: begin
        w.emit     = 1'b1;
        w.src      = vfd_pkg::SRC_LIGHTS;
        w.fend_fix = 1'b1;
        w.act      = vfd_pkg::ACT_CLEAR;
        w.nxt      = vfd_pkg::STEP_WRCMD;
      end
      vfd_pkg::STEP_WRCMD: begin
        w.emit = 1'b1;
        w.src  = vfd_pkg::SRC_RAM_WRITE;
        w.act  = vfd_pkg::ACT_LOAD_CNT;
        w.br   = vfd_pkg::BR_COND;
        w.csel = vfd_pkg::COND_NZERO;
        w.nxt  = vfd_pkg::STEP_WRCELL;
      end
      vfd_pkg::STEP_WRCELL: begin
        w.emit = 1'b1;
        w.src  = vfd_pkg::SRC_CELL;
        w.act  = vfd_pkg::ACT_DEC_CNT;
        w.br   = vfd_pkg::BR_COND;
        w.csel = vfd_pkg::COND_CNT1;
        w.nxt  = vfd_pkg::STEP_WRCELL;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic vfd_pkg::step_t entry(input logic [2:0] kind);
    vfd_pkg::step_t s;
    unique case (kind)
      vfd_pkg::KIND_SET_CHAR:   s = vfd_pkg::STEP_SETCHAR;
      vfd_pkg::KIND_BRIGHTNESS: s = vfd_pkg::STEP_BRIGHT;
      vfd_pkg::KIND_CLEAR:      s = vfd_pkg::STEP_CLEAR;
      vfd_pkg::KIND_WRITE:      s = vfd_pkg::STEP_WRCMD;
      vfd_pkg::KIND_INIT:       s = vfd_pkg::STEP_INIT0;
      default:                  s = vfd_pkg::STEP_IDLE;
    endcase
    return s;
  endfunction

  assign word     = microcode(upc_r);
  assign cond_hit = (word.csel == vfd_pkg::COND_NZERO) ? stat.n_zero : stat.cnt_one;
  // the step that leaves for idle closes the item
  assign done     = (word.br == vfd_pkg::BR_COND) ? cond_hit
                                                  : (word.nxt == vfd_pkg::STEP_IDLE);

  // next step
  always_comb begin
    upc_nxt = upc_r;
    if (upc_r == vfd_pkg::STEP_IDLE) begin
      if (in_ch.valid) begin
        upc_nxt = entry(in_ch.kind);
      end
    end else if (word.emit == 1'b0 || stat.out_free) begin
      upc_nxt = done ? vfd_pkg::STEP_IDLE : word.nxt;
    end
  end

  // outputs
  always_comb begin
    in_ch.ready = (upc_r == vfd_pkg::STEP_IDLE);
    ctrl.load   = in_ch.ready && in_ch.valid;
    ctrl.go     = (upc_r != vfd_pkg::STEP_IDLE) && (word.emit == 1'b0 || stat.out_free);
    ctrl.last   = word.emit && done;
    ctrl.fend   = word.fend_fix || (word.br == vfd_pkg::BR_COND && cond_hit);
    ctrl.word   = word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= vfd_pkg::STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.go && ctrl.last |=> upc_r == vfd_pkg::STEP_IDLE)
    else $error("sequencer did not return to idle after the final byte");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.go |-> !ctrl.load)
    else $error("input taken while a step is running");

endmodule

// File: design/vfd_dp.sv
module vfd_dp #(
  parameter int MAX_DIGITS = vfd_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  vfd_in_if.sink             in_ch,
  vfd_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  vfd_pkg::seq_ctrl_t ctrl,
  output vfd_pkg::dp_stat_t  stat
);

  localparam int IDXW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LIMIT = (MAX_DIGITS < vfd_pkg::CELL_LIMIT) ? MAX_DIGITS
                                                            : vfd_pkg::CELL_LIMIT;

  logic [3:0]        digit_count_r;
  logic [3:0]        n_used;
  logic signed [4:0] pos_r;
  logic [7:0]        char_r;
  logic [7:0]        lvl_r;
  logic [3:0]        cnt_r;
  logic [3:0]        cnt_nxt;
  logic [7:0]        cells_r   [MAX_DIGITS];
  logic [7:0]        cells_nxt [MAX_DIGITS];
  logic [IDXW-1:0]   rd_idx;
  logic [IDXW-1:0]   wr_idx;
  logic              pos_ok;
  logic [3:0]        lvl_sat;
  logic [7:0]        byte_sel;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_fend_r;
  logic              out_last_r;
  logic              emit_go;

  assign n_used  = (digit_count_r > 4'(LIMIT)) ? 4'(LIMIT) : digit_count_r;
  assign rd_idx  = IDXW'(cnt_r - 4'd1);
  assign wr_idx  = IDXW'(pos_r[3:0]);
  assign pos_ok  = !pos_r[4] && (pos_r[3:0] < n_used);
  assign lvl_sat = (lvl_r > vfd_pkg::LEVEL_MAX) ? 4'hF : lvl_r[3:0];
  assign emit_go = ctrl.go && ctrl.word.emit;

  assign stat.n_zero   = (n_used == 4'd0);
  assign stat.cnt_one  = (cnt_r == 4'd1);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    unique case (ctrl.word.src)
      vfd_pkg::SRC_DUTY_LVL:  byte_sel = vfd_pkg::CMD_DUTY | {4'b0, lvl_sat};
      vfd_pkg::SRC_DUTY_INIT: byte_sel = vfd_pkg::CMD_DUTY | {4'b0, vfd_pkg::DUTY_INIT};
      vfd_pkg::SRC_DIGITS:    byte_sel = vfd_pkg::CMD_DIGITS | {4'b0, n_used};
      vfd_pkg::SRC_LIGHTS:    byte_sel = vfd_pkg::CMD_LIGHTS | vfd_pkg::LIGHTS_NORMAL;
      vfd_pkg::SRC_RAM_WRITE: byte_sel = vfd_pkg::CMD_RAM_WRITE;
      vfd_pkg::SRC_CELL:      byte_sel = cells_r[rd_idx];
      default:                byte_sel = vfd_pkg::CMD_RAM_WRITE;
    endcase
  end

  // buffer updates and cell counter
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    if (ctrl.go) begin
      case (ctrl.word.act)
        vfd_pkg::ACT_SETCHAR: begin
          if (pos_ok) begin
            cells_nxt[wr_idx] = vfd_pkg::rom_code(char_r);
          end
        end
        vfd_pkg::ACT_CLEAR: begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (5'(i) < {1'b0, n_used}) begin
              cells_nxt[i] = vfd_pkg::SPACE_CODE;
            end
          end
        end
        vfd_pkg::ACT_LOAD_CNT: cnt_nxt = n_used;
        vfd_pkg::ACT_DEC_CNT:  cnt_nxt = cnt_r - 4'd1;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= vfd_pkg::DIGIT_COUNT_RST;
      out_valid_r   <= 1'b0;
      cnt_r         <= 4'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cells_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        digit_count_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

  // payload: capture fields on the input transfer, result on each emitted step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos_r  <= in_ch.position;
      char_r <= in_ch.character;
      lvl_r  <= in_ch.level;
    end
    if (emit_go) begin
      out_byte_r <= byte_sel;
      out_fend_r <= ctrl.fend;
      out_last_r <= ctrl.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bus_byte  = out_byte_r;
  assign out_ch.frame_end = out_fend_r;
  assign out_ch.last      = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (!out_valid_r || out_ch.ready))
    else $error("held result overwritten");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_fend_r)
    else $error("final byte of a command does not end its frame");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.go && ctrl.word.act == vfd_pkg::ACT_DEC_CNT |-> cnt_r != 4'd0 && cnt_r <= n_used)
    else $error("cell counter out of range during display write");

endmodule

// File: design/vfd_char_buffer_frame_sender.sv
// Character buffer and command byte sender for a fluorescent display controller.
// in_ch carries commands (kind, position, character, level); a command is taken
// on a cycle with in_ch.valid and in_ch.ready high. out_ch carries the bus bytes,
// each with frame_end (chip select released after it) and last (final byte of
// the command). cfg_we/cfg_data write the digit count; the user is to write it
// only while idle, which the block does not enforce. A microprogram walks one
// step per cycle while out_ch does not stall it; each step emits at most one byte.
// An idle sequencer takes a command and runs its steps. Set char and clear emit
// no byte, brightness one, write display the RAM-write command and then n cells,
// and initialize three setup bytes, a clear of the cells and a display write
// (n = cells in use, at most 12); the cell counter sets how many cells are sent.
// An output register holds the current byte, so the next command can be taken
// while the final byte of the previous one still waits.
// A held byte and low out_ch.ready stall the emitting step; the sequencer holds.
// Reset (rst_n low, synchronous) clears the buffer to zero, sets the digit
// count to 12, empties the output register and returns the sequencer to idle.
module vfd_char_buffer_frame_sender #(
  parameter int MAX_DIGITS = vfd_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vfd_in_if.sink     in_ch,
  vfd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  vfd_pkg::seq_ctrl_t ctrl;
  vfd_pkg::dp_stat_t  stat;

  vfd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  vfd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .stat     (stat)
  );

endmodule

// File: tb/vfd_char_buffer_frame_sender_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] bus_byte;
  logic       frame_end;
  logic       last;
} bus_beat_t;

class frame_scoreboard;
  logic [7:0]  cells [vfd_pkg::CELL_LIMIT];
  logic [3:0]  digit_count;
  logic [8:0]  frame_bytes[$];
  bus_beat_t   beats_due[$];
  int unsigned errors;

  function new();
    foreach (cells[i]) cells[i] = 8'd0;
    digit_count = vfd_pkg::DIGIT_COUNT_RST;
    errors      = 0;
  endfunction

  function void set_digit_count(logic [3:0] value);
    digit_count = value;
  endfunction

  function int unsigned cells_in_use();
    int unsigned n;
    n = digit_count;
    if (n > vfd_pkg::MAX_DIGITS_DEF) n = vfd_pkg::MAX_DIGITS_DEF;
    if (n > vfd_pkg::CELL_LIMIT) n = vfd_pkg::CELL_LIMIT;
    return n;
  endfunction

  function int unsigned pending();
    return beats_due.size();
  endfunction

  function logic [7:0] char_to_code(logic [7:0] c);
    if (c < 8'd32 || c > 8'd122 || c == 8'd96) return vfd_pkg::BAD_CODE;
    if (c < 8'd64) return c + 8'd16;
    if (c < 8'd96) return c - 8'd48;
    return c - 8'd80;
  endfunction

  function void blank_cells();
    for (int unsigned i = 0; i < cells_in_use(); i++) cells[i] = vfd_pkg::SPACE_CODE;
  endfunction

  // RAM-write command, then the cells from the highest one down
  function void add_write_frame();
    int unsigned n;
    n = cells_in_use();
    frame_bytes.push_back({vfd_pkg::CMD_RAM_WRITE, n == 0});
    for (int unsigned i = n; i > 0; i--) frame_bytes.push_back({cells[i - 1], i == 1});
  endfunction

  function void note_command(logic [2:0] kind, logic [4:0] pos, logic [7:0] ch,
                             logic [7:0] lvl);
    int unsigned n;
    bus_beat_t   beat;
    n = cells_in_use();
    frame_bytes.delete();
    case (kind)
      vfd_pkg::KIND_SET_CHAR: begin
        // negative or past the last cell in use: drop
        if (!pos[4] && pos[3:0] < n) cells[pos[3:0]] = char_to_code(ch);
      end
      vfd_pkg::KIND_BRIGHTNESS: begin
        if (lvl > vfd_pkg::LEVEL_MAX) lvl = vfd_pkg::LEVEL_MAX;
        frame_bytes.push_back({vfd_pkg::CMD_DUTY | lvl, 1'b1});
      end
      vfd_pkg::KIND_CLEAR: blank_cells();
      vfd_pkg::KIND_WRITE: add_write_frame();
      vfd_pkg::KIND_INIT: begin
        frame_bytes.push_back({vfd_pkg::CMD_DIGITS | 8'(n[3:0]), 1'b1});
        frame_bytes.push_back({vfd_pkg::CMD_DUTY | {4'd0, vfd_pkg::DUTY_INIT}, 1'b1});
        frame_bytes.push_back({vfd_pkg::CMD_LIGHTS | vfd_pkg::LIGHTS_NORMAL, 1'b1});
        blank_cells();
        add_write_frame();
      end
      default: ;
    endcase
    foreach (frame_bytes[i]) begin
      beat.bus_byte  = frame_bytes[i][8:1];
      beat.frame_end = frame_bytes[i][0];
      beat.last      = (i == frame_bytes.size() - 1);
      beats_due.push_back(beat);
    end
  endfunction

  function void check_byte(logic [7:0] bus_byte, logic frame_end, logic last);
    bus_beat_t want;
    if (beats_due.size() == 0) begin
      $error("unexpected bus byte 0x%02h (frame_end %0b, last %0b)", bus_byte, frame_end,
             last);
      errors++;
      return;
    end
    want = beats_due.pop_front();
    if (bus_byte !== want.bus_byte) begin
      $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, bus_byte);
      errors++;
    end
    if (frame_end !== want.frame_end) begin
      $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last);
      errors++;
    end
  endfunction
endclass

module vfd_char_buffer_frame_sender_tb;

  localparam logic [2:0]  KIND_SPARE_FIRST = vfd_pkg::KIND_INIT + 3'd1;
  localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;
  localparam int          NUM_PHASES       = 6;
  localparam int          ITEMS_PER_PHASE  = 12;
  localparam int          SETTLE_CYCLES    = 24;
  localparam int          HOLD_OFF_CYCLES  = 300;
  localparam longint      RUN_LIMIT_NS     = 5_000_000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_data;

  bit tx_steady;
  bit rx_steady;
  bit hold_off_req;

  frame_scoreboard sb;

  vfd_in_if  in_if();
  vfd_out_if out_if();

  vfd_char_buffer_frame_sender i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, a steady mode, and one long hold-off on request
  initial begin
    int unsigned span;
    out_if.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        span = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (rx_steady || $urandom_range(0, 2) != 0) begin
        out_if.ready <= 1'b1;
        span = $urandom_range(1, 8);
      end else begin
        out_if.ready <= 1'b0;
        span = gap_len();
        if (span == 0) span = 1;
      end
      repeat (span) @(negedge clk);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        sb.check_byte(out_if.bus_byte, out_if.frame_end, out_if.last);
    end
  end

  // enter and leave at a falling edge
  task automatic send_command(input logic [2:0] kind, input logic [4:0] pos,
                              input logic [7:0] ch, input logic [7:0] lvl);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.position  <= pos;
    in_if.character <= ch;
    in_if.level     <= lvl;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(kind, pos, ch, lvl);
    @(negedge clk);
    gap = tx_steady ? 0 : gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random_item(output bit counted);
    int unsigned pick;
    int unsigned n;
    logic [2:0]  kind;
    logic [4:0]  pos;
    logic [7:0]  ch;
    logic [7:0]  lvl;
    n    = sb.cells_in_use();
    pick = $urandom_range(0, 99);
    if (pick < 45)      kind = vfd_pkg::KIND_SET_CHAR;
    else if (pick < 60) kind = vfd_pkg::KIND_WRITE;
    else if (pick < 72) kind = vfd_pkg::KIND_BRIGHTNESS;
    else if (pick < 80) kind = vfd_pkg::KIND_CLEAR;
    else if (pick < 90) kind = vfd_pkg::KIND_INIT;
    else                kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    if (n != 0 && $urandom_range(0, 4) != 0) pos = 5'($urandom_range(0, n - 1));
    else                                     pos = 5'($urandom);
    ch  = $urandom_range(0, 1) ? 8'($urandom_range(32, 127)) : 8'($urandom);
    lvl = $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    send_command(kind, pos, ch, lvl);
    counted = (kind <= vfd_pkg::KIND_INIT);
  endtask

  // hold until every byte is in, then let zero-byte commands finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_digit_count(input logic [3:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_digit_count(value);
  endtask

  initial begin
    logic [3:0]  phase_counts [NUM_PHASES];
    int unsigned done;
    bit          counted;

    sb = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = 4'd0;
    in_if.valid     = 1'b0;
    in_if.kind      = vfd_pkg::KIND_SET_CHAR;
    in_if.position  = 5'd0;
    in_if.character = 8'd0;
    in_if.level     = 8'd0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    hold_off_req    = 1'b0;
    phase_counts    = '{4'd1, 4'd0, 4'd15, 4'd13, 4'd7, 4'd12};
    phase_counts[4] = 4'($urandom_range(2, 11));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset buffer, mapping edges, then positions, levels and the other kinds
    send_command(vfd_pkg::KIND_WRITE, 5'd0, 8'd0, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd0, 8'd64, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd1, 8'd95, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd2, 8'd32, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd3, 8'd63, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd4, 8'd97, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd5, 8'd122, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd6, 8'd96, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd7, 8'd255, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd8, 8'd31, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'd15, 8'd90, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'h1F, 8'd65, 8'd0);
    send_command(vfd_pkg::KIND_SET_CHAR, 5'h10, 8'd66, 8'd0);
    send_command(vfd_pkg::KIND_WRITE, 5'd0, 8'd0, 8'd0);
    send_command(vfd_pkg::KIND_BRIGHTNESS, 5'd0, 8'd0, 8'd0);
    send_command(vfd_pkg::KIND_BRIGHTNESS, 5'd0, 8'd0, 8'd15);
    send_command(vfd_pkg::KIND_BRIGHTNESS, 5'd0, 8'd0, 8'd16);
    send_command(vfd_pkg::KIND_BRIGHTNESS, 5'd0, 8'd0, 8'd255);
    send_command(KIND_SPARE_FIRST, 5'd3, 8'd65, 8'd7);
    send_command(KIND_SPARE_FIRST + 3'd1, 5'd3, 8'd65, 8'd7);
    send_command(KIND_SPARE_LAST, 5'd3, 8'd65, 8'd7);
    send_command(vfd_pkg::KIND_CLEAR, 5'd0, 8'd0, 8'd0);
    send_command(vfd_pkg::KIND_WRITE, 5'd0, 8'd0, 8'd0);
    send_command(vfd_pkg::KIND_INIT, 5'd0, 8'd0, 8'd0);
    send_command(vfd_pkg::KIND_INIT, 5'd0, 8'd0, 8'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_digit_count(phase_counts[p]);
      tx_steady = (p == 2) || (p == NUM_PHASES - 1);
      rx_steady = (p == 3);
      // last phase: stall the result side long enough to back up the input
      if (p == NUM_PHASES - 1) hold_off_req = 1'b1;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        send_random_item(counted);
        if (counted) done++;
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: vfd_char_buffer_frame_sender.f
design/vfd_pkg.sv
design/vfd_if.sv
design/vfd_seq.sv
design/vfd_dp.sv
design/vfd_char_buffer_frame_sender.sv
tb/vfd_char_buffer_frame_sender_tb.sv
